[src/tsme_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsme_pkg
// Shared types and constants of the tile swap mosaic engine: field widths,
// default image geometry, request codes and the controller/datapath bundles.
// ---------------------------------------------------------------------------
package tsme_pkg;

  // default geometry
  localparam int TSME_IMAGE_WIDTH  = 256;
  localparam int TSME_IMAGE_HEIGHT = 256;
  localparam int TSME_TILE_SIZE    = 4;

  // field widths
  localparam int REQ_W   = 2;
  localparam int COORD_W = 8;
  localparam int TILE_W  = 6;
  localparam int RGB_W   = 24;
  // wide enough for any image dimension in range
  localparam int DIM_W   = 13;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SWAP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted request
    logic pix_wr;     // single pixel write
    logic pix_rd;     // single pixel read
    logic corner_rd;  // read both top-left pixels
    logic score;      // register before/after distances
    logic set_swap;   // mark the trial as swapped
    logic tile_rd;    // read one pixel pair of the tiles
    logic tile_wr_p;  // write first tile pixel
    logic tile_wr_q;  // write second tile pixel
    logic step;       // advance to the next pixel pair
    logic res_load;   // load the output register
  } tsme_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             tiles_ok;
    logic             better;
    logic             last_pixel;
  } tsme_sts_t;

endpackage
`default_nettype wire

[src/tsme_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsme_ctrl
// Sequencer of the mosaic engine: takes one request at a time, steps the
// datapath through pixel access, scoring and tile exchange, and owns the
// output valid flag.
// ---------------------------------------------------------------------------
module tsme_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tsme_pkg::tsme_sts_t sts_i,
  output tsme_pkg::tsme_cmd_t      cmd_o
);
  import tsme_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SCORE    = 3'd2;
  localparam logic [2:0] ST_DECIDE   = 3'd3;
  localparam logic [2:0] ST_TILE_RD  = 3'd4;
  localparam logic [2:0] ST_TILE_WP  = 3'd5;
  localparam logic [2:0] ST_TILE_WQ  = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.req)
          REQ_WRITE: begin
            cmd_o.pix_wr = 1'b1;
            state_d      = ST_DONE;
          end
          REQ_READ: begin
            cmd_o.pix_rd = 1'b1;
            state_d      = ST_DONE;
          end
          REQ_SWAP: begin
            if (sts_i.tiles_ok) begin
              cmd_o.corner_rd = 1'b1;
              state_d         = ST_SCORE;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_SCORE: begin
        cmd_o.score = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.better) begin
          cmd_o.set_swap = 1'b1;
          state_d        = ST_TILE_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_TILE_RD: begin
        cmd_o.tile_rd = 1'b1;
        state_d       = ST_TILE_WP;
      end
      ST_TILE_WP: begin
        cmd_o.tile_wr_p = 1'b1;
        state_d         = ST_TILE_WQ;
      end
      ST_TILE_WQ: begin
        cmd_o.tile_wr_q = 1'b1;
        cmd_o.step      = 1'b1;
        state_d         = sts_i.last_pixel ? ST_DONE : ST_TILE_RD;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[src/tsme_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsme_datapath
// Pixel memory with one write and two read ports, request registers,
// address generation, corner scoring and the result register.
// ---------------------------------------------------------------------------
module tsme_datapath #(
  parameter int IMAGE_WIDTH  = tsme_pkg::TSME_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = tsme_pkg::TSME_IMAGE_HEIGHT,
  parameter int TILE_SIZE    = tsme_pkg::TSME_TILE_SIZE
) (
  input  wire logic                         clk_i,
  input  wire tsme_pkg::tsme_cmd_t          cmd_i,
  output tsme_pkg::tsme_sts_t               sts_o,
  input  wire logic [tsme_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [tsme_pkg::COORD_W-1:0] pixel_x_i,
  input  wire logic [tsme_pkg::COORD_W-1:0] pixel_y_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   pixel_rgb_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  first_tile_col_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  first_tile_row_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  second_tile_col_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  second_tile_row_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   first_target_rgb_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   second_target_rgb_i,
  output logic [tsme_pkg::RGB_W-1:0]        read_rgb_o,
  output logic                              swapped_o
);
  import tsme_pkg::*;

  localparam int DEPTH     = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int PW        = AW + DIM_W;
  localparam int TILE_COLS = IMAGE_WIDTH / TILE_SIZE;
  localparam int TILE_ROWS = IMAGE_HEIGHT / TILE_SIZE;
  localparam int TSW       = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int ROW_STEP  = IMAGE_WIDTH - TILE_SIZE + 1;

  // distance of one pixel to one target, 0 to 765
  function automatic logic [9:0] l1_rgb(input logic [RGB_W-1:0] a,
                                        input logic [RGB_W-1:0] b);
    logic [7:0] d_r, d_g, d_b;
    d_r = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
    d_g = (a[15:8] > b[15:8])   ? a[15:8] - b[15:8]   : b[15:8] - a[15:8];
    d_b = (a[7:0] > b[7:0])     ? a[7:0] - b[7:0]     : b[7:0] - a[7:0];
    return 10'(d_r) + 10'(d_g) + 10'(d_b);
  endfunction

  logic [RGB_W-1:0] mem [DEPTH];

  logic [REQ_W-1:0] req_q;
  logic             pix_ok_q, tiles_ok_q;
  logic [RGB_W-1:0] rgb_q, t1_q, t2_q;
  logic [AW-1:0]    pix_addr_q, p_addr_q, q_addr_q;
  logic [TSW-1:0]   dx_q, dy_q;
  logic [10:0]      before_q, after_q;
  logic             swap_q;
  logic [RGB_W-1:0] rdata_a_q, rdata_b_q;
  logic [RGB_W-1:0] read_rgb_q;
  logic             swapped_q;

  logic [PW-1:0]    pix_lin, p_lin, q_lin;
  logic             pix_ok, tiles_ok, row_end;

  // request decode and linear addresses
  always_comb begin
    pix_ok   = (DIM_W'(pixel_x_i) < DIM_W'(IMAGE_WIDTH)) &&
               (DIM_W'(pixel_y_i) < DIM_W'(IMAGE_HEIGHT));
    tiles_ok = (DIM_W'(first_tile_col_i)  < DIM_W'(TILE_COLS)) &&
               (DIM_W'(first_tile_row_i)  < DIM_W'(TILE_ROWS)) &&
               (DIM_W'(second_tile_col_i) < DIM_W'(TILE_COLS)) &&
               (DIM_W'(second_tile_row_i) < DIM_W'(TILE_ROWS));
    pix_lin  = PW'(pixel_y_i) * PW'(IMAGE_WIDTH) + PW'(pixel_x_i);
    p_lin    = PW'(first_tile_row_i) * PW'(TILE_SIZE * IMAGE_WIDTH) +
               PW'(first_tile_col_i) * PW'(TILE_SIZE);
    q_lin    = PW'(second_tile_row_i) * PW'(TILE_SIZE * IMAGE_WIDTH) +
               PW'(second_tile_col_i) * PW'(TILE_SIZE);
  end

  assign row_end = (dx_q == TSW'(TILE_SIZE - 1));

  // request capture, pixel pair walk, scoring and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= req_type_i;
      pix_ok_q   <= pix_ok;
      tiles_ok_q <= tiles_ok;
      rgb_q      <= pixel_rgb_i;
      t1_q       <= first_target_rgb_i;
      t2_q       <= second_target_rgb_i;
      pix_addr_q <= pix_lin[AW-1:0];
      p_addr_q   <= p_lin[AW-1:0];
      q_addr_q   <= q_lin[AW-1:0];
      dx_q       <= '0;
      dy_q       <= '0;
      swap_q     <= 1'b0;
    end
    if (cmd_i.step) begin
      if (row_end) begin
        dx_q     <= '0;
        dy_q     <= dy_q + TSW'(1);
        p_addr_q <= p_addr_q + AW'(ROW_STEP);
        q_addr_q <= q_addr_q + AW'(ROW_STEP);
      end else begin
        dx_q     <= dx_q + TSW'(1);
        p_addr_q <= p_addr_q + AW'(1);
        q_addr_q <= q_addr_q + AW'(1);
      end
    end
    if (cmd_i.score) begin
      before_q <= 11'(l1_rgb(rdata_a_q, t1_q)) + 11'(l1_rgb(rdata_b_q, t2_q));
      after_q  <= 11'(l1_rgb(rdata_b_q, t1_q)) + 11'(l1_rgb(rdata_a_q, t2_q));
    end
    if (cmd_i.set_swap) begin
      swap_q <= 1'b1;
    end
    if (cmd_i.res_load) begin
      read_rgb_q <= (req_q == REQ_READ && pix_ok_q) ? rdata_a_q : '0;
      swapped_q  <= swap_q;
    end
  end

  logic             mem_we, mem_re;
  logic [AW-1:0]    wr_addr, rd_addr_a;
  logic [RGB_W-1:0] wr_data;

  // memory port selection
  always_comb begin
    mem_we    = (cmd_i.pix_wr && pix_ok_q) || cmd_i.tile_wr_p || cmd_i.tile_wr_q;
    mem_re    = (cmd_i.pix_rd && pix_ok_q) || cmd_i.corner_rd || cmd_i.tile_rd;
    wr_addr   = q_addr_q;
    wr_data   = rdata_a_q;
    if (cmd_i.pix_wr) begin
      wr_addr = pix_addr_q;
      wr_data = rgb_q;
    end else if (cmd_i.tile_wr_p) begin
      wr_addr = p_addr_q;
      wr_data = rdata_b_q;
    end
    rd_addr_a = cmd_i.pix_rd ? pix_addr_q : p_addr_q;
  end

  // pixel memory, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_a_q <= mem[rd_addr_a];
      rdata_b_q <= mem[q_addr_q];
    end
  end

  assign sts_o.req        = req_q;
  assign sts_o.tiles_ok   = tiles_ok_q;
  assign sts_o.better     = (after_q < before_q);
  assign sts_o.last_pixel = row_end && (dy_q == TSW'(TILE_SIZE - 1));

  assign read_rgb_o = read_rgb_q;
  assign swapped_o  = swapped_q;

endmodule
`default_nettype wire

[src/tile_swap_mosaic_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tile_swap_mosaic_engine
// Pixel image store with single pixel write/read and tile swap trials that
// exchange two tiles when that brings their top-left pixels closer to targets.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   request fields
//   out      output     out_valid_o / out_ready_i read_rgb_o, swapped_o
//
// One request at a time. A swapped trial walks each pixel pair of the tiles:
// each pair needs one read and two writes on the single memory write port.
// Reset clears only the control state; the pixel memory is not initialized.
// A result waiting in the output register does not block the next request;
// the request finishes and holds in its last step until the register frees.
// ---------------------------------------------------------------------------
module tile_swap_mosaic_engine #(
  parameter int IMAGE_WIDTH  = tsme_pkg::TSME_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = tsme_pkg::TSME_IMAGE_HEIGHT,
  parameter int TILE_SIZE    = tsme_pkg::TSME_TILE_SIZE
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tsme_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [tsme_pkg::COORD_W-1:0] pixel_x_i,
  input  wire logic [tsme_pkg::COORD_W-1:0] pixel_y_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   pixel_rgb_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  first_tile_col_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  first_tile_row_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  second_tile_col_i,
  input  wire logic [tsme_pkg::TILE_W-1:0]  second_tile_row_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   first_target_rgb_i,
  input  wire logic [tsme_pkg::RGB_W-1:0]   second_target_rgb_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tsme_pkg::RGB_W-1:0]        read_rgb_o,
  output logic                              swapped_o
);
  import tsme_pkg::*;

  tsme_cmd_t cmd;
  tsme_sts_t sts;

  // sequencer
  tsme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memory and arithmetic
  tsme_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .TILE_SIZE    (TILE_SIZE)
  ) u_datapath (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_type_i          (req_type_i),
    .pixel_x_i           (pixel_x_i),
    .pixel_y_i           (pixel_y_i),
    .pixel_rgb_i         (pixel_rgb_i),
    .first_tile_col_i    (first_tile_col_i),
    .first_tile_row_i    (first_tile_row_i),
    .second_tile_col_i   (second_tile_col_i),
    .second_tile_row_i   (second_tile_row_i),
    .first_target_rgb_i  (first_target_rgb_i),
    .second_target_rgb_i (second_target_rgb_i),
    .read_rgb_o          (read_rgb_o),
    .swapped_o           (swapped_o)
  );

`ifndef SYNTHESIS
  // an accepted request leaves the engine busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted twice in a row");

  // a swap result never carries read data
  a_swap_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && swapped_o |-> read_rgb_o == '0)
    else $error("swap result with read data");

  // tile and pixel writes only happen while a request is in progress
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.tile_wr_p || cmd.tile_wr_q || cmd.pix_wr))
    else $error("memory write while idle");
`endif

endmodule
`default_nettype wire
